// ===== sv/dibrt_pkg.sv =====
// Package for the DRAM interface bank/row tracker: request and result
// types, action and register word codes, address decode constants.
// No dependencies.
`default_nettype none

package dibrt_pkg;

  localparam int unsigned NumBanks = 8;
  localparam int unsigned NumWords = 6;
  localparam int unsigned BankW    = 3;
  localparam int unsigned RowW     = 9;
  localparam int unsigned TimeW    = 64;
  localparam int unsigned CountW   = 8;

  localparam logic [31:0] LowLimit   = 32'h0080_0000;
  localparam logic [31:0] ErrLimit   = 32'h03f0_0000;
  localparam logic [31:0] ActiveCode = 32'h0000_0014;
  localparam int unsigned RefreshEnBit = 17;
  localparam logic [2:0]  HighAccessErr = 3'b100;

  typedef enum logic [2:0] {
    ActRegRead  = 3'd0,
    ActRegWrite = 3'd1,
    ActAccess   = 3'd2,
    ActProbe    = 3'd3,
    ActRefresh  = 3'd4,
    ActTick     = 3'd5
  } action_e;

  // register word indexes (reg_offset bits 4..2)
  localparam logic [2:0] WordCtrl    = 3'd0;
  localparam logic [2:0] WordStatus  = 3'd2;
  localparam logic [2:0] WordMode    = 3'd3;
  localparam logic [2:0] WordRefresh = 3'd4;
  localparam logic [2:0] WordError   = 3'd6;
  localparam logic [2:0] WordBanks   = 3'd7;

  typedef struct packed {
    logic [2:0]       action;
    logic [31:0]      address;
    logic             is_write;
    logic [4:0]       reg_offset;
    logic [31:0]      write_data;
    logic [TimeW-1:0] timestamp;
  } req_t;

  typedef struct packed {
    logic [31:0]       read_data;
    logic              row_is_open;
    logic [TimeW-1:0]  access_time;
    logic [CountW-1:0] refresh_count;
    logic              refresh_started;
  } rsp_t;

  // command from the control block to the bank table
  typedef struct packed {
    logic             access;
    logic [BankW-1:0] bank;
    logic [RowW-1:0]  row;
    logic             is_write;
    logic [TimeW-1:0] stamp;
    logic             invalidate;
    logic             mark_dirty;
  } bank_cmd_t;

  // bank table status back to the control block
  typedef struct packed {
    logic [NumBanks-1:0] valid;
    logic [NumBanks-1:0] dirty;
    logic                hit;
    logic [TimeW-1:0]    last_time;
  } bank_sts_t;

endpackage

`default_nettype wire

// ===== sv/dibrt_bank_table.sv =====
// Eight-bank open-row table: valid, dirty, open row and last access time.
// Depends on dibrt_pkg.
`default_nettype none

module dibrt_bank_table (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire dibrt_pkg::bank_cmd_t cmd_i,
  output      dibrt_pkg::bank_sts_t sts_o
);

  logic [dibrt_pkg::NumBanks-1:0] valid_q, valid_d;
  logic [dibrt_pkg::NumBanks-1:0] dirty_q, dirty_d;
  logic [dibrt_pkg::RowW-1:0]     row_q [dibrt_pkg::NumBanks];
  logic [dibrt_pkg::TimeW-1:0]    time_q [dibrt_pkg::NumBanks];
  logic                           miss;

  assign miss = !valid_q[cmd_i.bank] || (row_q[cmd_i.bank] != cmd_i.row);

  always_comb begin
    valid_d = valid_q;
    dirty_d = dirty_q;
    if (cmd_i.invalidate) begin
      valid_d = '0;
    end
    if (cmd_i.mark_dirty) begin
      dirty_d = '1;
    end
    if (cmd_i.access) begin
      if (miss) begin
        valid_d[cmd_i.bank] = 1'b1;
        dirty_d[cmd_i.bank] = 1'b0;
      end
      if (cmd_i.is_write) begin
        dirty_d[cmd_i.bank] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      dirty_q <= '0;
      for (int i = 0; i < dibrt_pkg::NumBanks; i++) begin
        time_q[i] <= '0;
      end
    end else begin
      valid_q <= valid_d;
      dirty_q <= dirty_d;
      if (cmd_i.access) begin
        time_q[cmd_i.bank] <= cmd_i.stamp;
      end
    end
  end

  // row is only compared while the bank is valid
  always_ff @(posedge clk_i) begin
    if (cmd_i.access && miss) begin
      row_q[cmd_i.bank] <= cmd_i.row;
    end
  end

  assign sts_o.valid     = valid_q;
  assign sts_o.dirty     = dirty_q;
  assign sts_o.hit       = !miss;
  assign sts_o.last_time = time_q[cmd_i.bank];

endmodule

`default_nettype wire

// ===== sv/dibrt_ctrl.sv =====
// Request decode, register file, error bits, bus-active flag and refresh
// counter; builds the bank table command and the result word.
// Depends on dibrt_pkg.
`default_nettype none

module dibrt_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 en_i,
  input  wire dibrt_pkg::req_t      req_i,
  input  wire dibrt_pkg::bank_sts_t sts_i,
  output      dibrt_pkg::bank_cmd_t cmd_o,
  output      dibrt_pkg::rsp_t      rsp_o
);

  logic [31:0] words_q [dibrt_pkg::NumWords];
  logic [31:0] words_d [dibrt_pkg::NumWords];
  logic        loaded_q, loaded_d;
  logic        active_q, active_d;
  logic [2:0]  err_q, err_d;
  logic [dibrt_pkg::CountW-1:0] cnt_q, cnt_d;

  logic [2:0]  word;
  logic        low_addr;
  logic        any_dirty;
  logic        refresh_ok;

  assign word       = req_i.reg_offset[4:2];
  assign low_addr   = req_i.address < dibrt_pkg::LowLimit;
  assign any_dirty  = |(sts_i.valid & sts_i.dirty);
  assign refresh_ok = words_q[dibrt_pkg::WordRefresh][dibrt_pkg::RefreshEnBit] && active_q &&
                      (cnt_q == '0);

  always_comb begin
    words_d  = words_q;
    loaded_d = loaded_q;
    active_d = active_q;
    err_d    = err_q;
    cnt_d    = cnt_q;

    cmd_o            = '0;
    cmd_o.bank       = req_i.address[22:20];
    cmd_o.row        = req_i.address[19:11];
    cmd_o.is_write   = req_i.is_write;
    cmd_o.stamp      = req_i.timestamp;

    rsp_o = '0;

    if (en_i) begin
      case (req_i.action)
        dibrt_pkg::ActRegRead: begin
          case (word)
            dibrt_pkg::WordStatus: begin
              rsp_o.read_data = {27'd0, words_q[dibrt_pkg::WordMode][4],
                                 words_q[dibrt_pkg::WordCtrl][3], 2'b11, err_q[0]};
            end
            dibrt_pkg::WordError: begin
              rsp_o.read_data = {29'd0, err_q};
            end
            dibrt_pkg::WordBanks: begin
              rsp_o.read_data = {16'd0, sts_i.dirty, sts_i.valid};
            end
            default: begin
              for (int i = 0; i < dibrt_pkg::NumWords; i++) begin
                if (word == 3'(i)) begin
                  rsp_o.read_data = words_q[i];
                end
              end
            end
          endcase
        end
        dibrt_pkg::ActRegWrite: begin
          case (word)
            dibrt_pkg::WordError: begin
              err_d = '0;
            end
            dibrt_pkg::WordBanks: begin
              cmd_o.invalidate = 1'b1;
              cmd_o.mark_dirty = 1'b1;
            end
            default: begin
              for (int i = 0; i < dibrt_pkg::NumWords; i++) begin
                if (word == 3'(i)) begin
                  words_d[i] = req_i.write_data;
                end
              end
              if (word == dibrt_pkg::WordStatus) begin
                loaded_d = 1'b1;
              end
              if (word == dibrt_pkg::WordStatus || word == dibrt_pkg::WordMode) begin
                active_d = loaded_d &&
                           (words_d[dibrt_pkg::WordMode] == dibrt_pkg::ActiveCode);
              end
            end
          endcase
        end
        dibrt_pkg::ActAccess: begin
          if (!low_addr) begin
            if (req_i.address < dibrt_pkg::ErrLimit) begin
              err_d = err_q | dibrt_pkg::HighAccessErr;
            end
          end else begin
            cmd_o.access = active_q;
          end
        end
        dibrt_pkg::ActProbe: begin
          if (!low_addr) begin
            rsp_o.row_is_open = 1'b1;
            rsp_o.access_time = req_i.timestamp;
          end else begin
            rsp_o.row_is_open = !active_q || sts_i.hit;
            rsp_o.access_time = sts_i.last_time;
          end
        end
        dibrt_pkg::ActRefresh: begin
          if (refresh_ok) begin
            cmd_o.invalidate      = 1'b1;
            rsp_o.refresh_started = 1'b1;
            cnt_d = any_dirty ? words_q[dibrt_pkg::WordRefresh][15:8]
                              : words_q[dibrt_pkg::WordRefresh][7:0];
          end
        end
        dibrt_pkg::ActTick: begin
          if (cnt_q != '0) begin
            cnt_d = cnt_q - 8'd1;
          end
        end
        default: begin
        end
      endcase
    end

    rsp_o.refresh_count = cnt_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < dibrt_pkg::NumWords; i++) begin
        words_q[i] <= '0;
      end
      loaded_q <= 1'b0;
      active_q <= 1'b0;
      err_q    <= '0;
      cnt_q    <= '0;
    end else begin
      words_q  <= words_d;
      loaded_q <= loaded_d;
      active_q <= active_d;
      err_q    <= err_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

`default_nettype wire

// ===== sv/dram_interface_bank_row_tracker.sv =====
// Top level of the DRAM interface bank/row tracker: input register, control
// and bank table, result register. Depends on dibrt_pkg, dibrt_ctrl and
// dibrt_bank_table.
`default_nettype none

// One request is taken per clock (busy stays low) and each request gives
// exactly one result. A request accepted at a clock edge is applied to the
// register file and bank table during the next cycle, and its result is
// driven with done_o high during the cycle after that, as set by the input
// register and the result register around the single update stage. The
// receiver cannot stall; results are shown for one cycle.
module dram_interface_bank_row_tracker (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start,
  output      logic            busy,
  input  wire dibrt_pkg::req_t req_i,
  output      logic            done_o,
  output      dibrt_pkg::rsp_t rsp_o
);

  dibrt_pkg::req_t      req_q;
  logic                 vld_q;
  dibrt_pkg::rsp_t      rsp_d, rsp_q;
  logic                 done_q;
  dibrt_pkg::bank_cmd_t bank_cmd;
  dibrt_pkg::bank_sts_t bank_sts;
  logic                 accept;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      vld_q  <= accept;
      done_q <= vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= req_i;
    end
    if (vld_q) begin
      rsp_q <= rsp_d;
    end
  end

  dibrt_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (vld_q),
    .req_i  (req_q),
    .sts_i  (bank_sts),
    .cmd_o  (bank_cmd),
    .rsp_o  (rsp_d)
  );

  dibrt_bank_table u_banks (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (bank_cmd),
    .sts_o  (bank_sts)
  );

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  // every accepted request produces a result once it has passed the input and result registers
  a_done_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> ##1 done_o)
    else $error("request accepted without a result");

  // no bank is touched unless the control stage holds a request
  a_no_idle_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !vld_q |-> !bank_cmd.access && !bank_cmd.invalidate && !bank_cmd.mark_dirty)
    else $error("bank table updated without a request");

  // between back-to-back results the refresh counter only holds or counts down, unless a refresh starts
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && $past(done_o) && !rsp_o.refresh_started |->
      (rsp_o.refresh_count == $past(rsp_o.refresh_count)) ||
      (rsp_o.refresh_count == $past(rsp_o.refresh_count) - 8'd1))
    else $error("refresh counter jumped without a refresh");

endmodule

`default_nettype wire

// ===== verif/tb_dram_interface_bank_row_tracker.sv =====
// Testbench for dram_interface_bank_row_tracker: directed and random requests
// checked against an in-bench model of the register file and bank tracker.
// Depends on dibrt_pkg and the RTL top level.
module tb_dram_interface_bank_row_tracker;

  localparam int StallLimit = 2000;

  logic            clk_i;
  logic            rst_ni;
  logic            start;
  logic            busy;
  dibrt_pkg::req_t req_i;
  logic            done_o;
  dibrt_pkg::rsp_t rsp_o;

  dram_interface_bank_row_tracker u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .req_i  (req_i),
    .done_o (done_o),
    .rsp_o  (rsp_o)
  );

  always #1 clk_i = ~clk_i;

  // tracker model state
  logic [31:0]                    trk_words [dibrt_pkg::NumWords];
  logic                           trk_loaded;
  logic                           trk_active;
  logic [2:0]                     trk_err;
  logic [dibrt_pkg::NumBanks-1:0] trk_valid;
  logic [dibrt_pkg::NumBanks-1:0] trk_dirty;
  logic [dibrt_pkg::RowW-1:0]     trk_row [dibrt_pkg::NumBanks];
  logic [dibrt_pkg::TimeW-1:0]    trk_stamp [dibrt_pkg::NumBanks];
  logic [dibrt_pkg::CountW-1:0]   trk_count;

  dibrt_pkg::rsp_t expected_rsp_q [$];
  int   fail_count;
  int   stall_cycles;
  bit   gaps_on;

  // Applies one request to the model and returns the result it should give.
  function automatic dibrt_pkg::rsp_t predict_tracker(input dibrt_pkg::req_t r);
    dibrt_pkg::rsp_t             o;
    logic [2:0]                  w;
    logic [dibrt_pkg::BankW-1:0] b;
    logic [dibrt_pkg::RowW-1:0]  rw;
    logic                        any_dirty;
    o  = '0;
    w  = r.reg_offset[4:2];
    b  = r.address[22:20];
    rw = r.address[19:11];
    case (r.action)
      dibrt_pkg::ActRegRead: begin
        case (w)
          dibrt_pkg::WordStatus: o.read_data = {27'd0, trk_words[dibrt_pkg::WordMode][4],
                                                trk_words[dibrt_pkg::WordCtrl][3],
                                                2'b11, trk_err[0]};
          dibrt_pkg::WordError:  o.read_data = {29'd0, trk_err};
          dibrt_pkg::WordBanks:  o.read_data = {16'd0, trk_dirty, trk_valid};
          default:               o.read_data = trk_words[w];
        endcase
      end
      dibrt_pkg::ActRegWrite: begin
        case (w)
          dibrt_pkg::WordError: trk_err = '0;
          dibrt_pkg::WordBanks: begin
            trk_valid = '0;
            trk_dirty = '1;
          end
          default: begin
            trk_words[w] = r.write_data;
            if (w == dibrt_pkg::WordStatus) trk_loaded = 1'b1;
            if (w == dibrt_pkg::WordStatus || w == dibrt_pkg::WordMode)
              trk_active = trk_loaded &&
                           trk_words[dibrt_pkg::WordMode] == dibrt_pkg::ActiveCode;
          end
        endcase
      end
      dibrt_pkg::ActAccess: begin
        if (r.address >= dibrt_pkg::LowLimit) begin
          if (r.address < dibrt_pkg::ErrLimit) trk_err = trk_err | dibrt_pkg::HighAccessErr;
        end else if (trk_active) begin
          if (!trk_valid[b] || trk_row[b] != rw) begin
            trk_row[b]   = rw;
            trk_valid[b] = 1'b1;
            trk_dirty[b] = 1'b0;
          end
          if (r.is_write) trk_dirty[b] = 1'b1;
          trk_stamp[b] = r.timestamp;
        end
      end
      dibrt_pkg::ActProbe: begin
        if (r.address >= dibrt_pkg::LowLimit) begin
          o.row_is_open = 1'b1;
          o.access_time = r.timestamp;
        end else begin
          // stamp is reported even while the bus is down
          o.row_is_open = !trk_active || (trk_valid[b] && trk_row[b] == rw);
          o.access_time = trk_stamp[b];
        end
      end
      dibrt_pkg::ActRefresh: begin
        if (trk_words[dibrt_pkg::WordRefresh][dibrt_pkg::RefreshEnBit] && trk_active &&
            trk_count == '0) begin
          any_dirty = |(trk_valid & trk_dirty);
          trk_valid = '0;
          trk_count = any_dirty ? trk_words[dibrt_pkg::WordRefresh][15:8]
                                : trk_words[dibrt_pkg::WordRefresh][7:0];
          o.refresh_started = 1'b1;
        end
      end
      dibrt_pkg::ActTick: begin
        if (trk_count != '0) trk_count = trk_count - 8'd1;
      end
      default: ;
    endcase
    o.refresh_count = trk_count;
    return o;
  endfunction

  function automatic void note_mismatch(input string what, input logic [63:0] want,
                                        input logic [63:0] got);
    if (got !== want) begin
      fail_count++;
      if (fail_count <= 10)
        $display("mismatch on %s: expected %h, got %h", what, want, got);
    end
  endfunction

  // Result check and stall watchdog.
  always @(posedge clk_i) begin : result_check
    dibrt_pkg::rsp_t want;
    if (rst_ni) begin
      if (done_o) begin
        if (expected_rsp_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("result with no request pending: %h", rsp_o);
        end else begin
          want = expected_rsp_q.pop_front();
          note_mismatch("read_data", 64'(want.read_data), 64'(rsp_o.read_data));
          note_mismatch("row_is_open", 64'(want.row_is_open), 64'(rsp_o.row_is_open));
          note_mismatch("access_time", want.access_time, rsp_o.access_time);
          note_mismatch("refresh_count", 64'(want.refresh_count),
                        64'(rsp_o.refresh_count));
          note_mismatch("refresh_started", 64'(want.refresh_started),
                        64'(rsp_o.refresh_started));
        end
      end
      if ((start && !busy) || done_o) begin
        stall_cycles = 0;
      end else if (stall_cycles >= StallLimit) begin
        $display("tb_dram_interface_bank_row_tracker: FAIL");
        $finish;
      end else begin
        stall_cycles++;
      end
    end
  end

  function automatic dibrt_pkg::req_t scrambled_request();
    dibrt_pkg::req_t r;
    r.action     = dibrt_pkg::ActTick;
    r.address    = $urandom;
    r.is_write   = 1'($urandom);
    r.reg_offset = 5'($urandom);
    r.write_data = $urandom;
    r.timestamp  = {$urandom, $urandom};
    return r;
  endfunction

  // Mostly low addresses over a few rows so that rows hit and miss.
  function automatic logic [31:0] pick_address();
    logic [dibrt_pkg::BankW-1:0] bank;
    logic [dibrt_pkg::RowW-1:0]  row;
    logic [10:0]                 col;
    int                          roll;
    bank = 3'($urandom_range(0, 7));
    col  = 11'($urandom);
    case ($urandom_range(0, 3))
      0:       row = '0;
      1:       row = 9'd1;
      2:       row = '1;
      default: row = 9'($urandom);
    endcase
    roll = $urandom_range(0, 99);
    if (roll < 75) return {9'd0, bank, row, col};
    if (roll < 85) return $urandom_range(dibrt_pkg::LowLimit, dibrt_pkg::ErrLimit - 1);
    return $urandom;
  endfunction

  task automatic send_request(input dibrt_pkg::req_t r);
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
    start <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (busy);
    expected_rsp_q.push_back(predict_tracker(r));
  endtask

  task automatic reg_read_req(input logic [2:0] w);
    dibrt_pkg::req_t r;
    logic [1:0]      lo;
    r  = scrambled_request();
    lo = 2'($urandom);
    r.action     = dibrt_pkg::ActRegRead;
    r.reg_offset = {w, lo};
    send_request(r);
  endtask

  task automatic reg_write_req(input logic [2:0] w, input logic [31:0] d);
    dibrt_pkg::req_t r;
    logic [1:0]      lo;
    r  = scrambled_request();
    lo = 2'($urandom);
    r.action     = dibrt_pkg::ActRegWrite;
    r.reg_offset = {w, lo};
    r.write_data = d;
    send_request(r);
  endtask

  task automatic access_req(input logic [31:0] a, input logic wr, input logic [63:0] ts);
    dibrt_pkg::req_t r;
    r = scrambled_request();
    r.action    = dibrt_pkg::ActAccess;
    r.address   = a;
    r.is_write  = wr;
    r.timestamp = ts;
    send_request(r);
  endtask

  task automatic probe_req(input logic [31:0] a, input logic [63:0] ts);
    dibrt_pkg::req_t r;
    r = scrambled_request();
    r.action    = dibrt_pkg::ActProbe;
    r.address   = a;
    r.timestamp = ts;
    send_request(r);
  endtask

  task automatic plain_req(input dibrt_pkg::action_e act);
    dibrt_pkg::req_t r;
    r = scrambled_request();
    r.action = act;
    send_request(r);
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (expected_rsp_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic test_register_file();
    reg_read_req(dibrt_pkg::WordStatus);
    reg_read_req(dibrt_pkg::WordBanks);
    reg_write_req(dibrt_pkg::WordCtrl, '1);
    reg_write_req(dibrt_pkg::WordMode, dibrt_pkg::ActiveCode);
    reg_write_req(dibrt_pkg::WordStatus, '0);       // loads word 2, bus comes up
    reg_read_req(dibrt_pkg::WordStatus);
    reg_read_req(dibrt_pkg::WordMode);
    reg_write_req(dibrt_pkg::WordError, '1);
    reg_read_req(dibrt_pkg::WordError);
  endtask

  task automatic test_row_tracking();
    access_req(32'h0, 1'b1, '0);
    access_req(dibrt_pkg::LowLimit - 1, 1'b0, '1);
    probe_req(32'h0, {$urandom, $urandom});
    probe_req(32'h0000_0800, {$urandom, $urandom});
    access_req(dibrt_pkg::ErrLimit - 1, 1'b1, {$urandom, $urandom});
    access_req(dibrt_pkg::ErrLimit, 1'b0, {$urandom, $urandom});
    probe_req('1, '1);
    reg_read_req(dibrt_pkg::WordError);
    // bus down: accesses ignored, probes report open
    reg_write_req(dibrt_pkg::WordMode, '0);
    access_req(32'h0010_1800, 1'b1, {$urandom, $urandom});
    probe_req(32'h0010_1800, {$urandom, $urandom});
    reg_write_req(dibrt_pkg::WordMode, dibrt_pkg::ActiveCode);
  endtask

  task automatic test_refresh();
    plain_req(dibrt_pkg::ActRefresh);               // enable bit clear
    reg_write_req(dibrt_pkg::WordRefresh, 32'h0002_0201);
    plain_req(dibrt_pkg::ActRefresh);
    plain_req(dibrt_pkg::ActRefresh);               // counter still running
    repeat (3) plain_req(dibrt_pkg::ActTick);       // last one ticks at zero
    reg_read_req(dibrt_pkg::WordBanks);
  endtask

  task automatic test_random_traffic(input int count, input bit allow_gaps);
    int          roll;
    logic [2:0]  w;
    logic [31:0] d;
    for (int n = 0; n < count; n++) begin
      if (n % 50 == 0) gaps_on = allow_gaps && $urandom_range(0, 2) != 0;
      roll = $urandom_range(0, 99);
      w    = 3'($urandom);
      d    = $urandom;
      if (roll < 10) begin
        reg_read_req(w);
      end else if (roll < 22) begin
        if (w == dibrt_pkg::WordMode && $urandom_range(0, 3) != 0) d = dibrt_pkg::ActiveCode;
        if (w == dibrt_pkg::WordRefresh) begin
          d[dibrt_pkg::RefreshEnBit] = $urandom_range(0, 3) != 0;
          if ($urandom_range(0, 9) != 0) d[15:8] = 8'($urandom_range(0, 5));
          if ($urandom_range(0, 9) != 0) d[7:0] = 8'($urandom_range(0, 5));
        end
        reg_write_req(w, d);
      end else if (roll < 60) begin
        access_req(pick_address(), 1'($urandom), {$urandom, $urandom});
      end else if (roll < 78) begin
        probe_req(pick_address(), {$urandom, $urandom});
      end else if (roll < 86) begin
        plain_req(dibrt_pkg::ActRefresh);
      end else begin
        plain_req(dibrt_pkg::ActTick);
      end
    end
  endtask

  initial begin
    clk_i      = 1'b0;
    rst_ni     = 1'b0;
    start      = 1'b0;
    req_i      = '0;
    fail_count = 0;
    stall_cycles = 0;
    gaps_on    = 1'b1;
    foreach (trk_words[i]) trk_words[i] = '0;
    foreach (trk_row[i]) begin
      trk_row[i]   = '0;
      trk_stamp[i] = '0;
    end
    trk_loaded = 1'b0;
    trk_active = 1'b0;
    trk_err    = '0;
    trk_valid  = '0;
    trk_dirty  = '0;
    trk_count  = '0;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_register_file();
    test_row_tracking();
    test_refresh();
    test_random_traffic(300, 1'b1);
    drain_results();
    test_random_traffic(300, 1'b1);
    test_random_traffic(100, 1'b0);
    drain_results();

    if (fail_count == 0) begin
      $display("tb_dram_interface_bank_row_tracker: PASS");
    end else begin
      $display("tb_dram_interface_bank_row_tracker: FAIL");
    end
    $finish;
  end

endmodule
